### design/bmhq_pkg.sv
package bmhq_pkg;

  // Key limits used as error values and as the empty-heap minimum.
  localparam logic signed [31:0] INT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;

  // Opcodes of an input transaction.
  localparam logic [1:0] OP_INSERT   = 2'd0;
  localparam logic [1:0] OP_EXTRACT  = 2'd1;
  localparam logic [1:0] OP_DECREASE = 2'd2;
  localparam logic [1:0] OP_DELETE   = 2'd3;

  // Result status codes.
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_FULL   = 3'd1;
  localparam logic [2:0] ST_EMPTY  = 3'd2;
  localparam logic [2:0] ST_BADPOS = 3'd3;
  localparam logic [2:0] ST_NOTDEC = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       accept;     // latch the input transaction
    logic       set_err;    // finish with an error status
    logic [2:0] err_code;
    logic       ins_start;  // place new key in a hole at the end
    logic       res_root;   // result is the current root
    logic       cnt_dec;    // one entry fewer
    logic       rd_pos;     // read the entry at the given position
    logic       dec_start;  // start sifting the decreased key up
    logic       del_start;  // start forcing the entry to the root
    logic       rd_parent;  // read the parent of the hole
    logic       up_move;    // parent moves down into the hole
    logic       wr_cur;     // moving key settles into the hole
    logic       rd_last;    // read the last entry
    logic       load_last;  // last entry becomes the moving key at the root
    logic       rd_kids;    // read both children of the hole
    logic       dn_move;    // smaller child moves up into the hole
    logic       publish;    // load the output register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] op;
    logic       full;
    logic       empty;
    logic       pos_bad;
    logic       not_dec;
    logic       at_root;
    logic       force_up;
    logic       cnt_one;
    logic       up_go;
    logic       dn_go;
    logic       out_busy;
  } dp_stat_t;

endpackage

### design/bmhq_ram.sv
module bmhq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and two registered read ports.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

### design/bmhq_datapath.sv
module bmhq_datapath #(
  parameter int DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  bmhq_pkg::dp_cmd_t          cmd,
  output bmhq_pkg::dp_stat_t         stat,
  input  logic [1:0]                 in_opcode,
  input  logic signed [31:0]         in_new_value,
  input  logic [3:0]                 in_position,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [31:0]         out_result_value,
  output logic [2:0]                 out_status,
  output logic signed [31:0]         out_min_value,
  output logic [$clog2(DEPTH+1)-1:0] out_entry_count
);

  import bmhq_pkg::*;

  localparam int AW  = $clog2(DEPTH);
  localparam int CW  = $clog2(DEPTH + 1);
  localparam int LW  = AW + 2;
  localparam int PCW = (CW > 4) ? CW : 4;

  // Transaction registers.
  logic [1:0]          op_r, op_nxt;
  logic signed [31:0]  key_r, key_nxt;
  logic [3:0]          pos_r, pos_nxt;
  // Sift state: the moving key and the hole it looks for.
  logic signed [31:0]  cur_r, cur_nxt;
  logic [AW-1:0]       idx_r, idx_nxt;
  logic                force_r, force_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic signed [31:0]  root_r, root_nxt;
  logic signed [31:0]  res_r, res_nxt;
  logic [2:0]          st_r, st_nxt;
  // Output register.
  logic                ovld_r, ovld_nxt;
  logic signed [31:0]  ores_r, ores_nxt;
  logic [2:0]          ost_r, ost_nxt;
  logic signed [31:0]  omin_r, omin_nxt;
  logic [CW-1:0]       ocnt_r, ocnt_nxt;

  // Memory ports.
  logic                we;
  logic [AW-1:0]       waddr, raddr_a, raddr_b;
  logic signed [31:0]  wdata, rd_a, rd_b;

  // Heap index arithmetic.
  logic [AW-1:0]       parent;
  logic [LW-1:0]       left_w, right_w, cnt_w;
  logic [PCW-1:0]      pos_w;
  logic [AW-1:0]       pos_addr;
  logic                l_ok, r_ok, take_l, take_r;
  logic signed [31:0]  best_l;

  bmhq_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_key_store (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  assign parent   = (idx_r - AW'(1)) >> 1;
  assign left_w   = {1'b0, idx_r, 1'b1};
  assign right_w  = left_w + LW'(1);
  assign cnt_w    = LW'(cnt_r);
  assign pos_w    = PCW'(pos_r);
  assign pos_addr = pos_w[AW-1:0];

  // Choose the smallest of the moving key and the children in range.
  assign l_ok   = left_w < cnt_w;
  assign r_ok   = right_w < cnt_w;
  assign take_l = l_ok && (rd_a < cur_r);
  assign best_l = take_l ? rd_a : cur_r;
  assign take_r = r_ok && (rd_b < best_l);

  // Status toward the controller.
  always_comb begin
    stat.op       = op_r;
    stat.full     = cnt_r >= CW'(DEPTH);
    stat.empty    = cnt_r == '0;
    stat.pos_bad  = pos_w >= PCW'(cnt_r);
    stat.not_dec  = key_r > rd_a;
    stat.at_root  = idx_r == '0;
    stat.force_up = force_r;
    stat.cnt_one  = cnt_r == CW'(1);
    stat.up_go    = force_r || (rd_a > cur_r);
    stat.dn_go    = take_l || take_r;
    stat.out_busy = ovld_r && !out_ready;
  end

  // Memory addressing and write data.
  always_comb begin
    we      = 1'b0;
    waddr   = idx_r;
    wdata   = cur_r;
    raddr_a = idx_r;
    raddr_b = right_w[AW-1:0];
    if (cmd.up_move) begin
      we    = 1'b1;
      wdata = rd_a;
    end
    if (cmd.dn_move) begin
      we    = 1'b1;
      wdata = take_r ? rd_b : rd_a;
    end
    if (cmd.wr_cur) begin
      we = 1'b1;
    end
    if (cmd.rd_pos) begin
      raddr_a = pos_addr;
    end
    if (cmd.rd_parent) begin
      raddr_a = parent;
    end
    if (cmd.rd_last) begin
      raddr_a = cnt_r[AW-1:0];
    end
    if (cmd.rd_kids) begin
      raddr_a = left_w[AW-1:0];
    end
  end

  // Next values of the working registers.
  always_comb begin
    op_nxt    = op_r;
    key_nxt   = key_r;
    pos_nxt   = pos_r;
    cur_nxt   = cur_r;
    idx_nxt   = idx_r;
    force_nxt = force_r;
    cnt_nxt   = cnt_r;
    res_nxt   = res_r;
    st_nxt    = st_r;
    root_nxt  = (we && waddr == '0) ? wdata : root_r;
    if (cmd.accept) begin
      op_nxt    = in_opcode;
      key_nxt   = in_new_value;
      pos_nxt   = in_position;
      st_nxt    = ST_OK;
      res_nxt   = INT_MIN;
      force_nxt = 1'b0;
    end
    if (cmd.set_err) begin
      st_nxt  = cmd.err_code;
      res_nxt = (cmd.err_code == ST_FULL) ? INT_MAX : INT_MIN;
    end
    if (cmd.ins_start) begin
      cur_nxt = key_r;
      idx_nxt = cnt_r[AW-1:0];
      cnt_nxt = cnt_r + CW'(1);
      res_nxt = key_r;
    end
    if (cmd.res_root) begin
      res_nxt = root_r;
    end
    if (cmd.cnt_dec) begin
      cnt_nxt = cnt_r - CW'(1);
    end
    if (cmd.dec_start) begin
      cur_nxt = key_r;
      idx_nxt = pos_addr;
      res_nxt = key_r;
    end
    if (cmd.del_start) begin
      idx_nxt   = pos_addr;
      res_nxt   = rd_a;
      force_nxt = 1'b1;
    end
    if (cmd.up_move) begin
      idx_nxt = parent;
    end
    if (cmd.load_last) begin
      cur_nxt   = rd_a;
      idx_nxt   = '0;
      force_nxt = 1'b0;
    end
    if (cmd.dn_move) begin
      idx_nxt = take_r ? right_w[AW-1:0] : left_w[AW-1:0];
    end
  end

  // Output register: a finished result waits here until taken.
  always_comb begin
    ovld_nxt = ovld_r && !out_ready;
    ores_nxt = ores_r;
    ost_nxt  = ost_r;
    omin_nxt = omin_r;
    ocnt_nxt = ocnt_r;
    if (cmd.publish) begin
      ovld_nxt = 1'b1;
      ores_nxt = res_r;
      ost_nxt  = st_r;
      omin_nxt = (cnt_r != '0) ? root_r : INT_MIN;
      ocnt_nxt = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      force_r <= 1'b0;
      ovld_r  <= 1'b0;
    end else begin
      cnt_r   <= cnt_nxt;
      force_r <= force_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    key_r  <= key_nxt;
    pos_r  <= pos_nxt;
    cur_r  <= cur_nxt;
    idx_r  <= idx_nxt;
    res_r  <= res_nxt;
    st_r   <= st_nxt;
    root_r <= root_nxt;
    ores_r <= ores_nxt;
    ost_r  <= ost_nxt;
    omin_r <= omin_nxt;
    ocnt_r <= ocnt_nxt;
  end

  assign out_valid        = ovld_r;
  assign out_result_value = ores_r;
  assign out_status       = ost_r;
  assign out_min_value    = omin_r;
  assign out_entry_count  = ocnt_r;

endmodule

### design/bmhq_ctrl.sv
module bmhq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  bmhq_pkg::dp_stat_t stat,
  output bmhq_pkg::dp_cmd_t  cmd
);

  import bmhq_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_DISPATCH = 10'b00_0000_0010,
    S_POS_WAIT = 10'b00_0000_0100,
    S_UP_RD    = 10'b00_0000_1000,
    S_UP_WR    = 10'b00_0001_0000,
    S_LAST_RD  = 10'b00_0010_0000,
    S_LAST_LD  = 10'b00_0100_0000,
    S_DN_RD    = 10'b00_1000_0000,
    S_DN_WR    = 10'b01_0000_0000,
    S_FINISH   = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = state_r == S_IDLE;

  // Sequencer for one transaction: check, sift up, sift down, publish.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_nxt = S_FINISH;
        if (stat.op == OP_INSERT) begin
          if (stat.full) begin
            cmd.set_err  = 1'b1;
            cmd.err_code = ST_FULL;
          end else begin
            cmd.ins_start = 1'b1;
            state_nxt     = S_UP_RD;
          end
        end else if (stat.op == OP_EXTRACT) begin
          if (stat.empty) begin
            cmd.set_err  = 1'b1;
            cmd.err_code = ST_EMPTY;
          end else begin
            cmd.res_root = 1'b1;
            cmd.cnt_dec  = 1'b1;
            state_nxt    = stat.cnt_one ? S_FINISH : S_LAST_RD;
          end
        end else if (stat.pos_bad) begin
          cmd.set_err  = 1'b1;
          cmd.err_code = ST_BADPOS;
        end else begin
          cmd.rd_pos = 1'b1;
          state_nxt  = S_POS_WAIT;
        end
      end
      S_POS_WAIT: begin
        if (stat.op == OP_DELETE) begin
          cmd.del_start = 1'b1;
          state_nxt     = S_UP_RD;
        end else if (stat.not_dec) begin
          cmd.set_err  = 1'b1;
          cmd.err_code = ST_NOTDEC;
          state_nxt    = S_FINISH;
        end else begin
          cmd.dec_start = 1'b1;
          state_nxt     = S_UP_RD;
        end
      end
      S_UP_RD: begin
        if (!stat.at_root) begin
          cmd.rd_parent = 1'b1;
          state_nxt     = S_UP_WR;
        end else if (stat.force_up) begin
          // Deleted entry reached the root: remove it like an extract.
          cmd.cnt_dec = 1'b1;
          state_nxt   = stat.cnt_one ? S_FINISH : S_LAST_RD;
        end else begin
          cmd.wr_cur = 1'b1;
          state_nxt  = S_FINISH;
        end
      end
      S_UP_WR: begin
        if (stat.up_go) begin
          cmd.up_move = 1'b1;
          state_nxt   = S_UP_RD;
        end else begin
          cmd.wr_cur = 1'b1;
          state_nxt  = S_FINISH;
        end
      end
      S_LAST_RD: begin
        cmd.rd_last = 1'b1;
        state_nxt   = S_LAST_LD;
      end
      S_LAST_LD: begin
        cmd.load_last = 1'b1;
        state_nxt     = S_DN_RD;
      end
      S_DN_RD: begin
        cmd.rd_kids = 1'b1;
        state_nxt   = S_DN_WR;
      end
      S_DN_WR: begin
        if (stat.dn_go) begin
          cmd.dn_move = 1'b1;
          state_nxt   = S_DN_RD;
        end else begin
          cmd.wr_cur = 1'b1;
          state_nxt  = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!stat.out_busy) begin
          cmd.publish = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### design/binary_min_heap_queue_core.sv
// Flow: an accepted transaction passes dispatch and bookkeeping, then walks the heap one level
// at a time (a key-store read, then a compare and a write); a delete may walk up and then down.
// Throughput: one transaction at a time; the next is taken the cycle after the result is
// placed in the output register, while that result may still wait to be taken.
// Reset: synchronous, active low; the heap comes up empty, the key store is not cleared.
module binary_min_heap_queue_core #(
  parameter int DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 in_opcode,
  input  logic signed [31:0]         in_new_value,
  input  logic [3:0]                 in_position,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [31:0]         out_result_value,
  output logic [2:0]                 out_status,
  output logic signed [31:0]         out_min_value,
  output logic [$clog2(DEPTH+1)-1:0] out_entry_count
);

  import bmhq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  bmhq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bmhq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_opcode        (in_opcode),
    .in_new_value     (in_new_value),
    .in_position      (in_position),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_value (out_result_value),
    .out_status       (out_status),
    .out_min_value    (out_min_value),
    .out_entry_count  (out_entry_count)
  );

  // The reported count never exceeds the heap capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_entry_count <= CW'(DEPTH))
    else $error("entry count beyond capacity");

  // A full report comes only from a heap that is full.
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_FULL) |-> out_entry_count == CW'(DEPTH))
    else $error("full status with spare room");

  // An empty heap reports the most negative key as its minimum.
  a_empty_min: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_entry_count == '0) |-> out_min_value == INT_MIN)
    else $error("empty heap reports a minimum key");

  // A new transaction is never taken while the datapath is publishing one.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.publish |-> !in_ready)
    else $error("input taken during publish");

endmodule

### verif/tb_binary_min_heap_queue_core.sv
module tb_binary_min_heap_queue_core;
  timeunit 1ns;
  timeprecision 1ps;

  import bmhq_pkg::*;

  localparam int DEPTH         = 16;
  localparam int CNT_W         = $clog2(DEPTH + 1);
  localparam int RANDOM_ITEMS  = 1270;
  localparam int QUIET_ITEMS   = 200;
  localparam int LONG_HOLD     = 400;
  localparam int HOLD_AT       = 300;
  localparam int DRAIN_AT      = 600;
  localparam int DRAIN_CYCLES  = 60;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int MAX_REPORTS   = 10;

  // One result transaction as the block reports it.
  typedef struct packed {
    logic signed [31:0] value;
    logic [2:0]         status;
    logic signed [31:0] minv;
    logic [CNT_W-1:0]   count;
  } heap_result_t;

  // One row of the directed table; typed rows carry their own expected result.
  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] key;
    logic [3:0]         pos;
    logic               typed;
    heap_result_t       res;
  } stim_row_t;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic [1:0]               in_opcode;
  logic signed [31:0]       in_new_value;
  logic [3:0]               in_position;
  logic                     out_valid;
  logic                     out_ready;
  logic signed [31:0]       out_result_value;
  logic [2:0]               out_status;
  logic signed [31:0]       out_min_value;
  logic [CNT_W-1:0]         out_entry_count;

  // Shadow heap of the predictor.
  logic signed [31:0] heap_keys [DEPTH];
  int unsigned        heap_fill;

  heap_result_t pending_results [$];
  stim_row_t    directed_rows [$];
  int           fail_count;
  int           idle_cycles;
  bit           quiet;
  bit           long_hold_req;

  binary_min_heap_queue_core #(
    .DEPTH(DEPTH)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_new_value     (in_new_value),
    .in_position      (in_position),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_value (out_result_value),
    .out_status       (out_status),
    .out_min_value    (out_min_value),
    .out_entry_count  (out_entry_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Move the entry at idx toward the root while its parent is larger, or all
  // the way up when to_root is set.
  function automatic void heap_sift_up(int unsigned idx, bit to_root);
    int unsigned        up;
    logic signed [31:0] t;
    while (idx != 0) begin
      up = (idx - 1) / 2;
      if (!to_root && heap_keys[up] <= heap_keys[idx]) break;
      t              = heap_keys[up];
      heap_keys[up]  = heap_keys[idx];
      heap_keys[idx] = t;
      idx            = up;
    end
  endfunction

  // Remove the root, refill it from the last entry and sift that key down.
  function automatic logic signed [31:0] heap_pop_root();
    logic signed [31:0] top;
    logic signed [31:0] t;
    int unsigned        idx;
    int unsigned        l;
    int unsigned        best;
    top = heap_keys[0];
    heap_fill--;
    if (heap_fill > 0) begin
      heap_keys[0] = heap_keys[heap_fill];
      idx = 0;
      while (1) begin
        l    = 2 * idx + 1;
        best = idx;
        if (l < heap_fill && heap_keys[l] < heap_keys[best]) best = l;
        if (l + 1 < heap_fill && heap_keys[l + 1] < heap_keys[best]) best = l + 1;
        if (best == idx) break;
        t               = heap_keys[idx];
        heap_keys[idx]  = heap_keys[best];
        heap_keys[best] = t;
        idx             = best;
      end
    end
    return top;
  endfunction

  // Apply one input transaction to the shadow heap and return its result.
  function automatic heap_result_t heap_apply(logic [1:0] op, logic signed [31:0] key,
                                              logic [3:0] pos);
    heap_result_t r;
    r.value  = INT_MIN;
    r.status = ST_OK;
    if (op == OP_INSERT) begin
      if (heap_fill >= DEPTH) begin
        r.status = ST_FULL;
        r.value  = INT_MAX;
      end else begin
        heap_keys[heap_fill] = key;
        heap_fill++;
        heap_sift_up(heap_fill - 1, 1'b0);
        r.value = key;
      end
    end else if (op == OP_EXTRACT) begin
      if (heap_fill == 0) r.status = ST_EMPTY;
      else r.value = heap_pop_root();
    end else if (pos >= heap_fill) begin
      r.status = ST_BADPOS;
    end else if (op == OP_DECREASE) begin
      if (key > heap_keys[pos]) begin
        r.status = ST_NOTDEC;
      end else begin
        heap_keys[pos] = key;
        heap_sift_up(pos, 1'b0);
        r.value = key;
      end
    end else begin
      heap_sift_up(pos, 1'b1);
      r.value = heap_pop_root();
    end
    r.minv  = (heap_fill != 0) ? heap_keys[0] : INT_MIN;
    r.count = heap_fill[CNT_W-1:0];
    return r;
  endfunction

  function automatic stim_row_t plain_row(logic [1:0] op, logic signed [31:0] key,
                                          logic [3:0] pos);
    stim_row_t s;
    s.op    = op;
    s.key   = key;
    s.pos   = pos;
    s.typed = 1'b0;
    s.res   = '0;
    return s;
  endfunction

  function automatic stim_row_t typed_row(logic [1:0] op, logic signed [31:0] key,
                                          logic [3:0] pos, logic signed [31:0] val,
                                          logic [2:0] st, logic signed [31:0] mn,
                                          int cnt);
    stim_row_t s;
    s = plain_row(op, key, pos);
    s.typed     = 1'b1;
    s.res.value = val;
    s.res.status = st;
    s.res.minv  = mn;
    s.res.count = cnt[CNT_W-1:0];
    return s;
  endfunction

  // Keys: extremes, full-range values and a narrow band that makes duplicates.
  function automatic logic signed [31:0] random_key();
    case ($urandom_range(0, 9))
      0:       return INT_MIN;
      1:       return INT_MAX;
      2, 3, 4: return $urandom;
      default: return $signed($urandom_range(0, 40)) - 32'sd20;
    endcase
  endfunction

  // Offer one input transaction, with an optional idle burst first, and record
  // its expected result when it is accepted. Starts and ends on a clock edge.
  task automatic send_txn(stim_row_t s);
    heap_result_t pred;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_opcode    <= s.op;
    in_new_value <= s.key;
    in_position  <= s.pos;
    do @(posedge clk); while (!in_ready);
    pred = heap_apply(s.op, s.key, s.pos);
    pending_results.push_back(s.typed ? s.res : pred);
  endtask

  // Result side ready: random stalls, one long hold on request, none at the end.
  initial begin : result_ready_drive
    int n;
    out_ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (long_hold_req) begin
        out_ready <= 1'b0;
        for (n = 0; n < LONG_HOLD; n++) @(posedge clk);
        long_hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // Compare each result transaction with the oldest expectation, and count
  // cycles in which neither channel moves a transaction.
  always @(posedge clk) begin : result_check
    heap_result_t want;
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("unexpected result: value %0d status %0d min %0d count %0d",
                     out_result_value, out_status, out_min_value, out_entry_count);
        end else begin
          want = pending_results.pop_front();
          if (out_result_value !== want.value || out_status !== want.status ||
              out_min_value !== want.minv || out_entry_count !== want.count) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display({"mismatch: expected value %0d status %0d min %0d count %0d, ",
                        "got value %0d status %0d min %0d count %0d"},
                       want.value, want.status, want.minv, want.count,
                       out_result_value, out_status, out_min_value, out_entry_count);
          end
        end
      end
    end
  end

  // Watchdog on a run that stops moving.
  initial begin : watchdog
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("binary_min_heap_queue_core test failed");
    $finish;
  end

  initial begin : stimulus
    stim_row_t          s;
    int                 i;
    int                 r;
    int                 ins_pct;
    longint             cur;
    longint             nv;
    fail_count    = 0;
    idle_cycles   = 0;
    quiet         = 1'b0;
    long_hold_req = 1'b0;
    heap_fill     = 0;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_opcode     <= OP_INSERT;
    in_new_value  <= '0;
    in_position   <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: error cases on an empty heap, the key extremes, an equal
    // key taken as a decrease, a larger key refused, then a fill to full.
    directed_rows.push_back(typed_row(OP_EXTRACT, 0, 0, INT_MIN, ST_EMPTY, INT_MIN, 0));
    directed_rows.push_back(typed_row(OP_DECREASE, 0, 0, INT_MIN, ST_BADPOS, INT_MIN, 0));
    directed_rows.push_back(typed_row(OP_DELETE, 0, 15, INT_MIN, ST_BADPOS, INT_MIN, 0));
    directed_rows.push_back(typed_row(OP_INSERT, INT_MAX, 0, INT_MAX, ST_OK, INT_MAX, 1));
    directed_rows.push_back(typed_row(OP_INSERT, INT_MIN, 0, INT_MIN, ST_OK, INT_MIN, 2));
    directed_rows.push_back(typed_row(OP_EXTRACT, 0, 0, INT_MIN, ST_OK, INT_MAX, 1));
    directed_rows.push_back(typed_row(OP_DECREASE, INT_MAX, 0, INT_MAX, ST_OK, INT_MAX, 1));
    directed_rows.push_back(typed_row(OP_DECREASE, 5, 1, INT_MIN, ST_BADPOS, INT_MAX, 1));
    directed_rows.push_back(typed_row(OP_DELETE, 0, 0, INT_MAX, ST_OK, INT_MIN, 0));
    directed_rows.push_back(typed_row(OP_INSERT, 7, 0, 7, ST_OK, 7, 1));
    directed_rows.push_back(typed_row(OP_DECREASE, 8, 0, INT_MIN, ST_NOTDEC, 7, 1));
    directed_rows.push_back(typed_row(OP_EXTRACT, 0, 0, 7, ST_OK, INT_MIN, 0));
    // Descending keys in equal pairs: each new key climbs toward the root, and
    // its twin stops below an equal parent.
    for (i = 0; i < DEPTH; i++)
      directed_rows.push_back(plain_row(OP_INSERT, 32'sd800 - 32'sd100 * (i / 2), 0));
    directed_rows.push_back(plain_row(OP_INSERT, 42, 0));
    directed_rows.push_back(plain_row(OP_DECREASE, INT_MIN, 15));
    directed_rows.push_back(plain_row(OP_DELETE, 0, 9));
    directed_rows.push_back(plain_row(OP_EXTRACT, 0, 0));
    foreach (directed_rows[k]) send_txn(directed_rows[k]);

    // Random part: fill and drain phases alternate so the heap keeps reaching
    // both full and empty; positions mostly hit live entries.
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == HOLD_AT) long_hold_req = 1'b1;
      if (i == DRAIN_AT) begin
        in_valid <= 1'b0;
        wait (pending_results.size() == 0);
        @(posedge clk);
      end
      quiet   = (i >= RANDOM_ITEMS - QUIET_ITEMS);
      ins_pct = ((i / 90) % 2 != 0) ? 75 : 30;
      r       = $urandom_range(0, 99);
      s.typed = 1'b0;
      s.res   = '0;
      if (r < ins_pct) s.op = OP_INSERT;
      else case (r % 3)
        0:       s.op = OP_EXTRACT;
        1:       s.op = OP_DECREASE;
        default: s.op = OP_DELETE;
      endcase
      if (heap_fill > 0 && $urandom_range(0, 99) < 85)
        s.pos = 4'($urandom_range(0, heap_fill - 1));
      else
        s.pos = 4'($urandom_range(0, 15));
      s.key = random_key();
      // A decrease mostly gets a key at or below the one it replaces.
      if (s.op == OP_DECREASE && s.pos < heap_fill && $urandom_range(0, 3) != 0) begin
        cur = heap_keys[s.pos];
        case ($urandom_range(0, 2))
          0:       nv = cur;
          1:       nv = cur - $urandom_range(1, 50);
          default: nv = cur - longint'($urandom);
        endcase
        if (nv < longint'(INT_MIN)) nv = INT_MIN;
        s.key = nv[31:0];
      end
      send_txn(s);
    end
    in_valid <= 1'b0;

    // Let every expected result arrive, then allow for any late extra one.
    wait (pending_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("binary_min_heap_queue_core test passed");
    end else begin
      $display("binary_min_heap_queue_core test failed");
    end
    $finish;
  end

endmodule

### binary_min_heap_queue_core.f
design/bmhq_pkg.sv
design/bmhq_ram.sv
design/bmhq_datapath.sv
design/bmhq_ctrl.sv
design/binary_min_heap_queue_core.sv
verif/tb_binary_min_heap_queue_core.sv
